// ----- rtl/core/chacha_stream_cipher_defines.svh -----
// ----------------------------------------------------------------------------
// chacha_stream_cipher_defines.svh
// Assertion macros used by the keystream block engine, ccs_keygen.
// ----------------------------------------------------------------------------
`ifndef CHACHA_STREAM_CIPHER_DEFINES_SVH
`define CHACHA_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define CCS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define CCS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/ccs_pkg.sv -----
// ----------------------------------------------------------------------------
// ccs_pkg
// Types, constants and round functions of the ChaCha stream cipher.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int BLOCK_BYTES = 64;
   localparam int POS_W       = $clog2(BLOCK_BYTES);
   localparam int STEP_W      = 6;

   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_BYTES - 1);

   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;

   localparam logic [3:0][31:0] SIGMA = {
      32'h6B206574, 32'h79622D32, 32'h3320646E, 32'h61707865
   };
   localparam logic [3:0][31:0] TAU = {
      32'h6B206574, 32'h79622D36, 32'h3120646E, 32'h61707865
   };

   localparam logic [1:0] ROUNDS_8  = 2'd0;
   localparam logic [1:0] ROUNDS_12 = 2'd1;
   localparam logic [1:0] ROUNDS_20 = 2'd2;

   typedef enum logic [2:0] {
      REG_KEY_01,
      REG_KEY_23,
      REG_KEY_45,
      REG_KEY_67,
      REG_KEY_IS_128,
      REG_ROUNDS,
      REG_INIT_12_13,
      REG_INIT_14_15
   } reg_index_type;

   typedef enum logic [1:0] {
      GEN_LOAD,
      GEN_ROUND,
      GEN_FEED
   } gen_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       keystream_only;
      logic       end_of_request;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       request_done;
   } rsp_type;

   typedef struct packed {
      logic [3:0][63:0] key;
      logic             key_is_128;
      logic [1:0]       rounds_select;
      logic [63:0]      nonce;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] ks_byte;
   } ks_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   function automatic logic [STEP_W-1:0] round_steps(logic [1:0] sel);
      case (sel)
         ROUNDS_8:  return STEP_W'(16);
         ROUNDS_12: return STEP_W'(24);
         default:   return STEP_W'(40);
      endcase
   endfunction

   // Half of a quarter round: two add-xor-rotate pairs.
   function automatic quad_type qr_half(quad_type q, logic second);
      word_type na;
      word_type nb;
      word_type nc;
      word_type nd;
      quad_type r;
      na = q.a + q.b;
      nd = q.d ^ na;
      nd = second ? {nd[23:0], nd[31:24]} : {nd[15:0], nd[31:16]};
      nc = q.c + nd;
      nb = q.b ^ nc;
      nb = second ? {nb[24:0], nb[31:25]} : {nb[19:0], nb[31:20]};
      r.a = na;
      r.b = nb;
      r.c = nc;
      r.d = nd;
      return r;
   endfunction

endpackage

// ----- rtl/core/chacha_stream_cipher.sv -----
// ----------------------------------------------------------------------------
// chacha_stream_cipher
// Byte-serial ChaCha stream cipher: data XOR keystream, or raw keystream.
// ----------------------------------------------------------------------------
// Requests enter a short queue and results leave through another; between
// them, one byte is served per cycle while a keystream block is held, a
// request is queued and the result queue has room. The block engine computes
// half a quarter round in all four lanes per cycle, so a 64-byte block
// takes a load step, the round steps for 8, 12 or 20 rounds and a
// feed-forward step. The next block is computed while the current one is
// consumed and is always done first, so a steady stream runs at one byte per
// cycle with one idle cycle after every 64 bytes, where the drained block is
// swapped for the next. After reset or any register write the first byte
// waits for a new block; a request that waits for it stays in the request queue.
// ----------------------------------------------------------------------------
module chacha_stream_cipher #(
   parameter int REQ_DEPTH = 2,
   parameter int RSP_DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ccs_pkg::req_type req_payload,
   output logic             empty,
   input  logic             pop,
   output ccs_pkg::rsp_type rsp_payload,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wr_data
);

   logic [3:0][63:0] key_ff;
   logic [3:0][63:0] key_in;
   logic             k128_ff;
   logic             k128_in;
   logic [1:0]       rsel_ff;
   logic [1:0]       rsel_in;
   logic [63:0]      init_ff;
   logic [63:0]      init_in;
   logic [63:0]      nonce_ff;
   logic [63:0]      nonce_in;
   logic [63:0]      ctr_init;

   ccs_pkg::cfg_type cfg;
   ccs_pkg::ks_type  ks;
   ccs_pkg::req_type req_head;
   ccs_pkg::rsp_type rsp_next;
   logic             req_q_empty;
   logic             rsp_q_full;
   logic             fire;

   always_comb begin
      key_in   = key_ff;
      k128_in  = k128_ff;
      rsel_in  = rsel_ff;
      init_in  = init_ff;
      nonce_in = nonce_ff;
      if (csr_wr_en) begin
         case (ccs_pkg::reg_index_type'(csr_index))
            ccs_pkg::REG_KEY_01:     key_in[0] = csr_wr_data;
            ccs_pkg::REG_KEY_23:     key_in[1] = csr_wr_data;
            ccs_pkg::REG_KEY_45:     key_in[2] = csr_wr_data;
            ccs_pkg::REG_KEY_67:     key_in[3] = csr_wr_data;
            ccs_pkg::REG_KEY_IS_128: k128_in   = csr_wr_data[0];
            ccs_pkg::REG_ROUNDS:     rsel_in   = csr_wr_data[1:0];
            ccs_pkg::REG_INIT_12_13: init_in   = csr_wr_data;
            ccs_pkg::REG_INIT_14_15: nonce_in  = csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         k128_ff  <= 1'b0;
         rsel_ff  <= ccs_pkg::ROUNDS_20;
         init_ff  <= '0;
         nonce_ff <= '0;
      end else begin
         key_ff   <= key_in;
         k128_ff  <= k128_in;
         rsel_ff  <= rsel_in;
         init_ff  <= init_in;
         nonce_ff <= nonce_in;
      end
   end

   assign ctr_init          = init_in;
   assign cfg.key           = key_ff;
   assign cfg.key_is_128    = k128_ff;
   assign cfg.rounds_select = rsel_ff;
   assign cfg.nonce         = nonce_ff;

   ccs_fifo #(
      .WIDTH ($bits(ccs_pkg::req_type)),
      .DEPTH (REQ_DEPTH)
   ) u_req_q (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (req_payload),
      .full    (full),
      .pop     (fire),
      .rd_data (req_head),
      .empty   (req_q_empty)
   );

   ccs_keygen u_keygen (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .restart  (csr_wr_en),
      .ctr_init (ctr_init),
      .take     (fire),
      .ks       (ks)
   );

   assign fire = !req_q_empty && ks.valid && !rsp_q_full;

   assign rsp_next.out_byte     = req_head.keystream_only ? ks.ks_byte
                                                          : req_head.data_byte ^ ks.ks_byte;
   assign rsp_next.request_done = req_head.end_of_request;

   ccs_fifo #(
      .WIDTH ($bits(ccs_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (fire),
      .wr_data (rsp_next),
      .full    (rsp_q_full),
      .pop     (pop),
      .rd_data (rsp_payload),
      .empty   (empty)
   );

endmodule

// ----- rtl/core/ccs_fifo.sv -----
// ----------------------------------------------------------------------------
// ccs_fifo
// Small first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module ccs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff;
   logic [AW-1:0]    wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff;
   logic [AW-1:0]    rd_ptr_in;
   logic [AW:0]      count_ff;
   logic [AW:0]      count_in;
   logic             push_ok;
   logic             pop_ok;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in  = count_ff + (AW+1)'(push_ok) - (AW+1)'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- rtl/core/ccs_keygen.sv -----
// ----------------------------------------------------------------------------
// ccs_keygen
// Keystream block engine: half a quarter round per lane per cycle, feed-forward
// into a held block, and a byte pointer that serves it one byte per take.
// ----------------------------------------------------------------------------
`include "chacha_stream_cipher_defines.svh"

module ccs_keygen (
   input  logic             clock,
   input  logic             reset,
   input  ccs_pkg::cfg_type cfg,
   input  logic             restart,
   input  logic [63:0]      ctr_init,
   input  logic             take,
   output ccs_pkg::ks_type  ks
);

   ccs_pkg::gen_state_type          state_ff;
   ccs_pkg::gen_state_type          state_in;
   logic [ccs_pkg::STEP_W-1:0]      step_ff;
   logic [ccs_pkg::STEP_W-1:0]      step_in;
   logic [ccs_pkg::STEP_W-1:0]      steps;
   ccs_pkg::block_type              x_ff;
   ccs_pkg::block_type              x_in;
   ccs_pkg::block_type              x_rnd;
   ccs_pkg::block_type              blk_ff;
   ccs_pkg::block_type              blk_in;
   ccs_pkg::block_type              blk_fed;
   ccs_pkg::block_type              s_word;
   logic                            blk_valid_ff;
   logic                            blk_valid_in;
   logic [63:0]                     ctr_ff;
   logic [63:0]                     ctr_in;
   logic [ccs_pkg::POS_W-1:0]       pos_ff;
   logic [ccs_pkg::POS_W-1:0]       pos_in;
   ccs_pkg::word_type               sel_word;

   assign steps = ccs_pkg::round_steps(cfg.rounds_select);

   always_comb begin
      logic [3:0][31:0] cst;
      cst = cfg.key_is_128 ? ccs_pkg::TAU : ccs_pkg::SIGMA;
      for (int i = 0; i < 4; i++) begin
         s_word[i]         = cst[i];
         s_word[4 + 2 * i] = cfg.key[i][31:0];
         s_word[5 + 2 * i] = cfg.key[i][63:32];
      end
      if (cfg.key_is_128) begin
         for (int i = 0; i < 4; i++) begin
            s_word[8 + i] = cfg.key[i / 2][32 * (i % 2) +: 32];
         end
      end
      s_word[12] = ctr_ff[31:0];
      s_word[13] = ctr_ff[63:32];
      s_word[14] = cfg.nonce[31:0];
      s_word[15] = cfg.nonce[63:32];
   end

   // Column round on even step pairs, diagonal round on odd ones.
   always_comb begin
      logic             diag;
      logic [3:0]       ia;
      logic [3:0]       ib;
      logic [3:0]       ic;
      logic [3:0]       id;
      ccs_pkg::quad_type q;
      ccs_pkg::quad_type r;
      diag  = step_ff[1];
      x_rnd = x_ff;
      for (int j = 0; j < 4; j++) begin
         ia  = {2'b00, 2'(j)};
         ib  = {2'b01, 2'(j) + (diag ? 2'd1 : 2'd0)};
         ic  = {2'b10, 2'(j) + (diag ? 2'd2 : 2'd0)};
         id  = {2'b11, 2'(j) + (diag ? 2'd3 : 2'd0)};
         q.a = x_ff[ia];
         q.b = x_ff[ib];
         q.c = x_ff[ic];
         q.d = x_ff[id];
         r   = ccs_pkg::qr_half(q, step_ff[0]);
         x_rnd[ia] = r.a;
         x_rnd[ib] = r.b;
         x_rnd[ic] = r.c;
         x_rnd[id] = r.d;
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         blk_fed[i] = x_ff[i] + s_word[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      x_in         = x_ff;
      blk_in       = blk_ff;
      blk_valid_in = blk_valid_ff;
      ctr_in       = ctr_ff;
      pos_in       = pos_ff;
      if (take) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff == ccs_pkg::LAST_POS) begin
            blk_valid_in = 1'b0;
         end
      end
      case (state_ff)
         ccs_pkg::GEN_LOAD: begin
            x_in     = s_word;
            step_in  = '0;
            state_in = ccs_pkg::GEN_ROUND;
         end
         ccs_pkg::GEN_ROUND: begin
            x_in    = x_rnd;
            step_in = step_ff + 1'b1;
            if (step_ff == steps - 1'b1) begin
               state_in = ccs_pkg::GEN_FEED;
            end
         end
         ccs_pkg::GEN_FEED: begin
            if (!blk_valid_ff) begin
               blk_in       = blk_fed;
               blk_valid_in = 1'b1;
               ctr_in       = ctr_ff + 64'd1;
               state_in     = ccs_pkg::GEN_LOAD;
            end
         end
         default: begin
            state_in = ccs_pkg::GEN_LOAD;
         end
      endcase
      if (restart) begin
         state_in     = ccs_pkg::GEN_LOAD;
         blk_valid_in = 1'b0;
         pos_in       = '0;
         ctr_in       = ctr_init;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ccs_pkg::GEN_LOAD;
         step_ff      <= '0;
         blk_valid_ff <= 1'b0;
         ctr_ff       <= '0;
         pos_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         blk_valid_ff <= blk_valid_in;
         ctr_ff       <= ctr_in;
         pos_ff       <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      blk_ff <= blk_in;
   end

   assign sel_word   = blk_ff[pos_ff[ccs_pkg::POS_W-1:2]];
   assign ks.valid   = blk_valid_ff;
   assign ks.ks_byte = sel_word[{pos_ff[1:0], 3'b000} +: 8];

   `CCS_ASSERT_SAME(a_take_needs_block, take, blk_valid_ff, "keystream taken with no block held")
   `CCS_ASSERT_NEXT(a_block_holds, blk_valid_ff && !restart && !(take && pos_ff == ccs_pkg::LAST_POS), blk_valid_ff, "block dropped before last byte")
   `CCS_ASSERT_SAME(a_step_bound, state_ff == ccs_pkg::GEN_ROUND, step_ff < steps, "round step past round count")
   `CCS_ASSERT_NEXT(a_ctr_advance, state_ff == ccs_pkg::GEN_FEED && !blk_valid_ff && !restart, ctr_ff == $past(ctr_ff) + 64'd1, "block counter did not advance on block write")

endmodule
